### hw/rtl/bss_pkg.sv
// shared types and codes for the bounded sorting stack
`default_nettype none

package bss_pkg;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SORT = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SORT_FIRST,
    S_SORT_STEP,
    S_SORT_END
  } state_t;

  // storage write data source
  typedef enum logic [1:0] {
    WSEL_PUSH,
    WSEL_MIN,
    WSEL_CARRY
  } wsel_t;

  // result read_value source
  typedef enum logic [1:0] {
    RSEL_ZERO,
    RSEL_ONES,
    RSEL_RAM
  } rsel_t;

  localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    op_t               op;
    logic signed [31:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    status_t            status;
    logic [4:0]         entry_count;
  } out_word_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    wsel_t   wsel;
    logic    carry_ld;
    logic    carry_max;
    logic    out_ld;
    rsel_t   rsel;
    status_t status;
  } seq_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/bss_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module bss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hw/rtl/bss_minmax.sv
// shared signed compare unit: splits two words into lower and higher
`default_nettype none

module bss_minmax (
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed      [31:0] lo,
  output logic signed      [31:0] hi
);

  logic a_gt_b;

  // one signed compare, then select
  always_comb begin
    a_gt_b = (a > b);
    lo     = a_gt_b ? b : a;
    hi     = a_gt_b ? a : b;
  end

endmodule

`default_nettype wire

### hw/rtl/bss_seq.sv
// sequencer: stack pointer, sort pass counters and datapath controls
`default_nettype none

module bss_seq #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire bss_pkg::op_t      op,
  output logic                   busy,
  output logic [AW-1:0]          rd_addr,
  output logic [AW-1:0]          wr_addr,
  output logic [CW-1:0]          cnt_nxt,
  output bss_pkg::seq_ctrl_t     ctrl
);

  bss_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r;
  logic [AW-1:0]   j_r, j_nxt;
  logic [AW-1:0]   lim_r, lim_nxt;
  logic            accept;
  logic            is_full;
  logic            is_empty;
  logic            few;
  logic            at_lim;
  logic            last_pass;
  logic [CW-1:0]   count_dec;

  always_comb begin
    accept    = start && (state_r == bss_pkg::S_IDLE);
    is_full   = (count_r == CW'(DEPTH));
    is_empty  = (count_r == '0);
    few       = (count_r < CW'(2));
    at_lim    = (j_r == lim_r);
    last_pass = (lim_r == AW'(1));
    count_dec = count_r - CW'(1);
  end

  assign busy = (state_r != bss_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bss_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op)
            bss_pkg::OP_PUSH: state_nxt = bss_pkg::S_IDLE;
            bss_pkg::OP_POP,
            bss_pkg::OP_PEEK: state_nxt = is_empty ? bss_pkg::S_IDLE : bss_pkg::S_READ;
            bss_pkg::OP_SORT: state_nxt = few ? bss_pkg::S_IDLE : bss_pkg::S_SORT_FIRST;
            default:          state_nxt = bss_pkg::S_IDLE;
          endcase
        end
      end
      bss_pkg::S_READ:       state_nxt = bss_pkg::S_IDLE;
      bss_pkg::S_SORT_FIRST: state_nxt = bss_pkg::S_SORT_STEP;
      bss_pkg::S_SORT_STEP:  state_nxt = at_lim ? bss_pkg::S_SORT_END : bss_pkg::S_SORT_STEP;
      bss_pkg::S_SORT_END:   state_nxt = last_pass ? bss_pkg::S_IDLE : bss_pkg::S_SORT_FIRST;
      default:               state_nxt = bss_pkg::S_IDLE;
    endcase
  end

  // outputs, counters and addresses
  always_comb begin
    ctrl      = '{rd_en: 1'b0, wr_en: 1'b0, wsel: bss_pkg::WSEL_PUSH, carry_ld: 1'b0,
                  carry_max: 1'b0, out_ld: 1'b0, rsel: bss_pkg::RSEL_ZERO,
                  status: bss_pkg::ST_DONE};
    cnt_nxt   = count_r;
    j_nxt     = j_r;
    lim_nxt   = lim_r;
    rd_addr   = '0;
    wr_addr   = '0;
    unique case (state_r)
      bss_pkg::S_IDLE: begin
        if (accept) begin
          ctrl.out_ld = 1'b1;
          unique case (op)
            bss_pkg::OP_PUSH: begin
              wr_addr = count_r[AW-1:0];
              if (is_full) begin
                ctrl.status = bss_pkg::ST_FULL;
              end else begin
                ctrl.wr_en = 1'b1;
                cnt_nxt    = count_r + CW'(1);
              end
            end
            bss_pkg::OP_POP,
            bss_pkg::OP_PEEK: begin
              rd_addr = count_dec[AW-1:0];
              if (is_empty) begin
                ctrl.rsel   = bss_pkg::RSEL_ONES;
                ctrl.status = bss_pkg::ST_EMPTY;
              end else begin
                // result is loaded once the read data is back
                ctrl.out_ld = 1'b0;
                ctrl.rd_en  = 1'b1;
                if (op == bss_pkg::OP_POP) begin
                  cnt_nxt = count_dec;
                end
              end
            end
            bss_pkg::OP_SORT: begin
              if (!few) begin
                ctrl.out_ld = 1'b0;
                ctrl.rd_en  = 1'b1;
                rd_addr     = '0;
                j_nxt       = AW'(1);
                lim_nxt     = count_dec[AW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      bss_pkg::S_READ: begin
        ctrl.out_ld = 1'b1;
        ctrl.rsel   = bss_pkg::RSEL_RAM;
      end
      bss_pkg::S_SORT_FIRST: begin
        // bottom entry becomes the carried word of this pass
        ctrl.carry_ld = 1'b1;
        ctrl.rd_en    = 1'b1;
        rd_addr       = j_r;
      end
      bss_pkg::S_SORT_STEP: begin
        // lower word drops one place, higher word is carried upward
        ctrl.carry_ld  = 1'b1;
        ctrl.carry_max = 1'b1;
        ctrl.wr_en     = 1'b1;
        ctrl.wsel      = bss_pkg::WSEL_MIN;
        wr_addr        = j_r - AW'(1);
        if (!at_lim) begin
          ctrl.rd_en = 1'b1;
          rd_addr    = j_r + AW'(1);
          j_nxt      = j_r + AW'(1);
        end
      end
      bss_pkg::S_SORT_END: begin
        // largest word of the pass lands on the pass top
        ctrl.wr_en = 1'b1;
        ctrl.wsel  = bss_pkg::WSEL_CARRY;
        wr_addr    = lim_r;
        if (last_pass) begin
          ctrl.out_ld = 1'b1;
        end else begin
          ctrl.rd_en = 1'b1;
          rd_addr    = '0;
          j_nxt      = AW'(1);
          lim_nxt    = lim_r - AW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bss_pkg::S_IDLE;
      count_r <= '0;
      j_r     <= '0;
      lim_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= cnt_nxt;
      j_r     <= j_nxt;
      lim_r   <= lim_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bounded_sorting_stack.sv
// Push and any empty or full case give the result word in the cycle after start; pop and
// peek of a held word read the entry ram, then load the result word from the read data.
// Sort of n entries runs n-1 bubble passes through one signed compare unit and the
// single-read-port entry ram; a sort of fewer than two entries answers like a push.
// Throughput: a new word is taken whenever busy is low; the result strobe cannot be stalled.
// Reset (rst_n low, synchronous) empties the stack and idles the sequencer; ram is not cleared.
`default_nettype none

module bounded_sorting_stack #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire bss_pkg::in_word_t  in_word,
  output logic                    busy,
  output logic                    out_strobe,
  output bss_pkg::out_word_t      out_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bss_pkg::seq_ctrl_t  ctrl;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [CW-1:0]       cnt_nxt;
  logic [CW+4:0]       cnt_ext;
  logic signed [31:0]  rd_data;
  logic signed [31:0]  wr_data;
  logic signed [31:0]  carry_r, carry_nxt;
  logic signed [31:0]  cmp_lo;
  logic signed [31:0]  cmp_hi;
  logic                out_strobe_r;
  bss_pkg::out_word_t  out_word_r, out_word_nxt;

  bss_seq #(.DEPTH(DEPTH)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .op      (in_word.op),
    .busy    (busy),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .cnt_nxt (cnt_nxt),
    .ctrl    (ctrl)
  );

  bss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (ctrl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctrl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bss_minmax u_minmax (
    .a  (carry_r),
    .b  (rd_data),
    .lo (cmp_lo),
    .hi (cmp_hi)
  );

  // write data and carried word
  always_comb begin
    unique case (ctrl.wsel)
      bss_pkg::WSEL_PUSH:  wr_data = in_word.push_value;
      bss_pkg::WSEL_MIN:   wr_data = cmp_lo;
      bss_pkg::WSEL_CARRY: wr_data = carry_r;
      default:             wr_data = carry_r;
    endcase
    carry_nxt = ctrl.carry_max ? cmp_hi : rd_data;
  end

  // result word
  always_comb begin
    cnt_ext = {5'd0, cnt_nxt};
    out_word_nxt.status      = ctrl.status;
    out_word_nxt.entry_count = cnt_ext[4:0];
    unique case (ctrl.rsel)
      bss_pkg::RSEL_ZERO: out_word_nxt.read_value = '0;
      bss_pkg::RSEL_ONES: out_word_nxt.read_value = bss_pkg::EMPTY_WORD;
      bss_pkg::RSEL_RAM:  out_word_nxt.read_value = rd_data;
      default:            out_word_nxt.read_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.carry_ld) begin
      carry_r <= carry_nxt;
    end
    if (ctrl.out_ld) begin
      out_word_r <= out_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctrl.out_ld;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // a result follows an accepted word or the end of a busy stretch
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a word in progress");

  // leaving busy always delivers the result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result");

  // an empty answer reads all ones on an empty stack
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.status == bss_pkg::ST_EMPTY) |->
      (out_word.read_value == bss_pkg::EMPTY_WORD && out_word.entry_count == 5'd0))
    else $error("empty status with wrong value or count");

endmodule

`default_nettype wire
